// File: hw/rtl/line_substring_filter_assert.svh
// Assertion helpers used by the checker of this block.
`ifndef LINE_SUBSTRING_FILTER_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lsf_pkg.sv
`default_nettype none

package lsf_pkg;

	localparam int PATTERN_BYTES = 32;
	localparam int PATLEN_W      = 6;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int LEN_W         = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH     = 3'd0,
		REG_CHARS_LOW          = 3'd1,
		REG_CHARS_MID_LOW      = 3'd2,
		REG_CHARS_MID_HIGH     = 3'd3,
		REG_CHARS_HIGH         = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             hit;
		logic [LEN_W-1:0] length;
		logic             truncated;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lsf_queue.sv
`default_nettype none

module lsf_queue
	import lsf_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  is_empty,
	output logic                  is_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == NW'(DEPTH));
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsf_front.sv
`default_nettype none

module lsf_front
	import lsf_pkg::*;
#(
	parameter int VW = 32
) (
	input  wire logic [7:0]          char_code,
	input  wire logic [8*VW-1:0]     pattern,
	input  wire logic [PATLEN_W-1:0] pattern_len,
	output logic                     is_newline,
	output logic      [VW-1:0]       eq_mask
);

	assign is_newline = (char_code == NEWLINE_CODE);

	// One comparator per pattern position; positions past the length never match.
	for (genvar j = 0; j < VW; j++) begin : g_cmp
		assign eq_mask[j] = (PATLEN_W'(j) < pattern_len) &&
			(pattern[8*j +: 8] == char_code);
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsf_back.sv
`default_nettype none

module lsf_back
	import lsf_pkg::*;
#(
	parameter int VW       = 32,
	parameter int MAX_LINE = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire logic                head_newline,
	input  wire logic [VW-1:0]       head_mask,
	input  wire logic [PATLEN_W-1:0] pattern_len,
	input  wire logic                res_full,
	output logic                     head_take,
	output logic                     res_write,
	output result_t                  res_data
);

	localparam int CW = $clog2(MAX_LINE);

	logic [VW-1:0] pil_vec_q;
	logic [VW-1:0] lip_vec_q;
	logic          seen_q;
	logic [CW-1:0] count_q;
	logic          overflow_q;

	logic          char_go;
	logic          at_limit;
	logic [VW-1:0] last_mask;
	logic [VW-1:0] pil_next;
	logic [VW-1:0] lip_next;
	logic [LEN_W-1:0] len_out;

	assign char_go   = head_valid && !head_newline;
	assign res_write = head_valid && head_newline && !res_full;
	assign head_take = char_go || res_write;
	assign at_limit  = (count_q >= CW'(MAX_LINE - 1));

	// Marks the bit of the vector that stands for the last pattern character.
	for (genvar j = 0; j < VW; j++) begin : g_last
		assign last_mask[j] = (pattern_len == PATLEN_W'(j + 1));
	end

	assign pil_next = ((pil_vec_q << 1) | VW'(1)) & head_mask;
	assign lip_next = (count_q == '0) ? head_mask : ((lip_vec_q << 1) & head_mask);

	if (CW >= LEN_W) begin : g_len_wide
		assign len_out = count_q[LEN_W-1:0];
	end else begin : g_len_narrow
		assign len_out = {{(LEN_W - CW){1'b0}}, count_q};
	end

	always_comb begin
		res_data.hit       = (pattern_len == '0) || seen_q || (count_q == '0) ||
			(|lip_vec_q);
		res_data.length    = len_out;
		res_data.truncated = overflow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pil_vec_q  <= '0;
			lip_vec_q  <= '0;
			seen_q     <= 1'b0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (res_write) begin
			pil_vec_q  <= '0;
			lip_vec_q  <= '0;
			seen_q     <= 1'b0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (char_go) begin
			if (at_limit) begin
				overflow_q <= 1'b1;
			end else begin
				pil_vec_q <= pil_next;
				lip_vec_q <= lip_next;
				count_q   <= count_q + 1'b1;
				if (|(pil_next & last_mask)) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/line_substring_filter.sv
// line_substring_filter: tests each text line against a pattern of up to 32 bytes.
// Text bytes come in on char_code with push/full; a beat is taken on an edge where
// push is high and full is low. A byte of value 10 ends the line and yields one
// result beat on line_matches, line_length and line_truncated, shown while empty
// is low and taken on an edge where pop is high. Other bytes yield no result.
// The block takes one byte per cycle while full is low. A newline's result is
// registered in the result queue and shown on the ports until popped; the newline
// waits while that queue is full. When the receiver stalls, results wait in a
// two-deep queue, then the back end stops and bytes fill a two-deep queue before
// full goes high. The pattern must be written via cfg_write/cfg_index/cfg_data
// only while idle; the block does not enforce it. Index 0 sets the length, indexes
// 1 to 4 set eight pattern bytes each. Reset clears the pattern, the line state
// and both queues; the block accepts bytes right after.
`default_nettype none

module line_substring_filter
	import lsf_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_LINE    = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [7:0]             char_code,
	input  wire logic                   push,
	output logic                        full,
	output logic                        line_matches,
	output logic      [LEN_W-1:0]       line_length,
	output logic                        line_truncated,
	output logic                        empty,
	input  wire logic                   pop
);

	// Vectors are as wide as the longest pattern that can ever take effect.
	localparam int VW = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
	localparam int EW = VW + 1;
	localparam int RW = $bits(result_t);

	logic [PATLEN_W-1:0]        pat_len_q;
	logic [8*PATTERN_BYTES-1:0] pattern_q;
	logic [PATLEN_W-1:0]        pat_len_eff;

	logic          front_newline;
	logic [VW-1:0] front_mask;
	logic [EW-1:0] head_entry;
	logic          mid_empty;
	logic          head_take;
	logic          res_write;
	logic          res_full;
	result_t       res_data;
	result_t       res_head;
	logic [RW-1:0] res_head_bits;

	// Configuration registers. Writes to indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			pattern_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[PATLEN_W-1:0];
				REG_CHARS_LOW:      pattern_q[63:0]    <= cfg_data;
				REG_CHARS_MID_LOW:  pattern_q[127:64]  <= cfg_data;
				REG_CHARS_MID_HIGH: pattern_q[191:128] <= cfg_data;
				REG_CHARS_HIGH:     pattern_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A length beyond what the vectors hold counts as the full vector width.
	assign pat_len_eff = (pat_len_q > PATLEN_W'(VW)) ? PATLEN_W'(VW) : pat_len_q;

	// Front end: classify the byte and compare it against every pattern position.
	lsf_front #(.VW(VW)) u_front (
		.char_code   (char_code),
		.pattern     (pattern_q[8*VW-1:0]),
		.pattern_len (pat_len_eff),
		.is_newline  (front_newline),
		.eq_mask     (front_mask)
	);

	// The queue between the ends carries the newline flag and the compare mask.
	lsf_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  ({front_newline, front_mask}),
		.rd_en    (head_take),
		.rd_data  (head_entry),
		.is_empty (mid_empty),
		.is_full  (full)
	);

	// Back end: shift-and update per kept byte, one result per newline.
	lsf_back #(.VW(VW), .MAX_LINE(MAX_LINE)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!mid_empty),
		.head_newline (head_entry[EW-1]),
		.head_mask    (head_entry[VW-1:0]),
		.pattern_len  (pat_len_eff),
		.res_full     (res_full),
		.head_take    (head_take),
		.res_write    (res_write),
		.res_data     (res_data)
	);

	// The result queue decouples the back end from a stalling receiver.
	lsf_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_write),
		.wr_data  (res_data),
		.rd_en    (pop),
		.rd_data  (res_head_bits),
		.is_empty (empty),
		.is_full  (res_full)
	);

	assign res_head       = result_t'(res_head_bits);
	assign line_matches   = res_head.hit;
	assign line_length    = res_head.length;
	assign line_truncated = res_head.truncated;

endmodule

`default_nettype wire

// File: hw/rtl/lsf_checker.sv
`default_nettype none
`include "line_substring_filter_assert.svh"

module lsf_checker
	import lsf_pkg::*;
#(
	parameter int MAX_LINE = 256
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire logic             line_matches,
	input wire logic [LEN_W-1:0] line_length,
	input wire logic             line_truncated
);

	localparam logic [LEN_W-1:0] LenAtLimit = LEN_W'((MAX_LINE - 1) % 256);
	localparam logic             ShortLines = (MAX_LINE <= 256);

	// A waiting result beat that is not taken stays put.
	`LSF_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(line_matches) && $stable(line_length) && $stable(line_truncated), "result changed while stalled")

	// The byte queue only fills up behind a result queue that holds a beat.
	`LSF_ASSERT_IMPLY(a_full_has_result, clk, arst_n, full, !empty, "input full with no result waiting")

	// A truncated line always reports the kept-length limit.
	`LSF_ASSERT_IMPLY(a_trunc_len, clk, arst_n, !empty && line_truncated, line_length == LenAtLimit, "truncated line with wrong length")

	// An empty line occurs in any pattern, so it always matches.
	`LSF_ASSERT_IMPLY(a_empty_line, clk, arst_n, ShortLines && !empty && line_length == '0, line_matches, "empty line reported as no match")

	// Push is part of the watched port set; it must never be unknown out of reset.
	`LSF_ASSERT_IMPLY(a_push_known, clk, arst_n, 1'b1, !$isunknown(push), "push is unknown")

endmodule

bind line_substring_filter lsf_checker #(.MAX_LINE(MAX_LINE)) u_lsf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.push           (push),
	.full           (full),
	.empty          (empty),
	.pop            (pop),
	.line_matches   (line_matches),
	.line_length    (line_length),
	.line_truncated (line_truncated)
);

`default_nettype wire
